// ===== hw/rtl/deq_pkg.sv =====
// Shared codes and types for the double-ended queue core.
`default_nettype none

package deq_pkg;

  // Fixed widths of the words on the channels
  localparam int OP_W   = 3;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  // Wide enough for any cell index or count up to the largest supported depth
  localparam int KEY_W  = 9;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
  localparam logic [OP_W-1:0] OP_ERASE      = 3'd5;
  localparam logic [OP_W-1:0] OP_READ       = 3'd6;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd7;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd3;

  // What the cell row does on an accepted word
  typedef enum logic [1:0] {
    SH_NONE,
    SH_INS,
    SH_DEL
  } shift_e;

  // Broadcast to every cell: the move and the index it starts at
  typedef struct packed {
    shift_e             mode;
    logic [KEY_W-1:0]   key;
  } shift_t;

endpackage

`default_nettype wire

// ===== hw/rtl/deq_req_if.sv =====
// Request channel: operation, position and value with valid/ready.
`default_nettype none

interface deq_req_if;
  import deq_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/deq_rsp_if.sv =====
// Response channel: read data, status, occupancy and position with valid/ready.
`default_nettype none

interface deq_rsp_if;
  import deq_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  occupancy;
  logic [POS_W-1:0]  result_position;

  modport source (output valid, output read_data, output status, output occupancy,
                  output result_position, input ready);
  modport sink   (input valid, input read_data, input status, input occupancy,
                  input result_position, output ready);
  modport mon    (input valid, input ready, input read_data, input status,
                  input occupancy, input result_position);
endinterface

`default_nettype wire

// ===== hw/rtl/deq_cell.sv =====
// One storage cell of the queue row; loads, shifts up or shifts down.
`default_nettype none

module deq_cell
  import deq_pkg::*;
#(
  parameter int WIDTH = 32,
  parameter int IDX   = 0
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire shift_t           shift_i,
  input  wire logic [WIDTH-1:0] word_i,
  input  wire logic [WIDTH-1:0] left_i,
  input  wire logic [WIDTH-1:0] right_i,
  output      logic [WIDTH-1:0] q_o
);

  localparam logic [KEY_W-1:0] MyIdx = KEY_W'(IDX);

  logic [WIDTH-1:0] word_q;
  logic [WIDTH-1:0] word_d;

  // New word: insert loads own slot, shifts later up; delete shifts down
  always_comb begin
    word_d = word_q;
    case (shift_i.mode)
      SH_INS: begin
        if (MyIdx == shift_i.key) begin
          word_d = word_i;
        end else if (MyIdx > shift_i.key) begin
          word_d = left_i;
        end
      end
      SH_DEL: begin
        if (MyIdx >= shift_i.key) begin
          word_d = right_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  // Advance only on an accepted word
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign q_o = word_q;

endmodule

`default_nettype wire

// ===== hw/rtl/deq_ctrl.sv =====
// Operation decode: checks bounds, picks the cell move and builds the result.
`default_nettype none

module deq_ctrl
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic [OP_W-1:0]                  operation_i,
  input  wire logic [POS_W-1:0]                 position_i,
  input  wire logic [$clog2(DEPTH+1)-1:0]       count_i,
  output      logic [$clog2(DEPTH+1)-1:0]       count_o,
  output      shift_t                           shift_o,
  output      logic                             rd_en_o,
  output      logic [$clog2(DEPTH)-1:0]         rd_idx_o,
  output      logic [STAT_W-1:0]                status_o,
  output      logic [POS_W-1:0]                 where_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int IdxW = $clog2(DEPTH);
  localparam int CmpW = (CntW > POS_W) ? CntW : POS_W;
  localparam logic [CntW-1:0] Full = CntW'(DEPTH);

  logic [CmpW-1:0] pos_x;
  logic [CmpW-1:0] cnt_x;
  logic [CmpW-1:0] where_x;
  logic            is_full;
  logic            is_empty;

  assign pos_x    = CmpW'(position_i);
  assign cnt_x    = CmpW'(count_i);
  assign is_full  = (count_i == Full);
  assign is_empty = (count_i == '0);

  // Decode the operation against the current count
  always_comb begin
    count_o       = count_i;
    shift_o.mode  = SH_NONE;
    shift_o.key   = '0;
    rd_en_o       = 1'b0;
    rd_idx_o      = IdxW'(position_i);
    status_o      = ST_OK;
    where_x       = cnt_x;
    case (operation_i)
      OP_PUSH_BACK: begin
        if (is_full) begin
          status_o = ST_FULL;
        end else begin
          shift_o.mode = SH_INS;
          shift_o.key  = KEY_W'(count_i);
          count_o      = count_i + 1'b1;
          where_x      = cnt_x;
        end
      end
      OP_PUSH_FRONT: begin
        if (is_full) begin
          status_o = ST_FULL;
        end else begin
          shift_o.mode = SH_INS;
          count_o      = count_i + 1'b1;
          where_x      = '0;
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          status_o = ST_EMPTY;
        end else begin
          rd_en_o  = 1'b1;
          rd_idx_o = IdxW'(count_i - 1'b1);
          count_o  = count_i - 1'b1;
          where_x  = CmpW'(count_i - 1'b1);
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status_o = ST_EMPTY;
        end else begin
          rd_en_o      = 1'b1;
          rd_idx_o     = '0;
          shift_o.mode = SH_DEL;
          count_o      = count_i - 1'b1;
          where_x      = '0;
        end
      end
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          status_o = ST_BAD_INDEX;
        end else if (is_full) begin
          status_o = ST_FULL;
        end else begin
          shift_o.mode = SH_INS;
          shift_o.key  = KEY_W'(position_i);
          count_o      = count_i + 1'b1;
          where_x      = pos_x;
        end
      end
      OP_ERASE: begin
        if (pos_x >= cnt_x) begin
          status_o = ST_BAD_INDEX;
        end else begin
          rd_en_o      = 1'b1;
          shift_o.mode = SH_DEL;
          shift_o.key  = KEY_W'(position_i);
          count_o      = count_i - 1'b1;
          where_x      = pos_x;
        end
      end
      OP_READ: begin
        if (pos_x >= cnt_x) begin
          status_o = ST_BAD_INDEX;
        end else begin
          rd_en_o = 1'b1;
          where_x = pos_x;
        end
      end
      OP_CLEAR: begin
        count_o = '0;
        where_x = '0;
      end
      default: status_o = ST_OK;
    endcase
  end

  assign where_o = where_x[POS_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/double_ended_queue_insert_erase_core.sv =====
// Top level of the double-ended queue: cell row, decode and response register.
//
//  channel | dir | word fields                                          | handshake
//  req_i   | in  | operation, position, value                           | valid/ready
//  rsp_o   | out | read_data, status, occupancy, result_position        | valid/ready
//
// One operation per cycle while the response register can take it: each word is decoded
// against the count and every cell loads or moves in the same cycle, also for middle insert and erase.
// The response sits in an output register; a new word is taken while that
// register is empty or being drained in the same cycle.
// Reset clears the count and the response valid; cell contents stay unknown
// until written and are never read before that.
`default_nettype none

module double_ended_queue_insert_erase_core
  import deq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  deq_req_if.sink    req_i,
  deq_rsp_if.source  rsp_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int IdxW = $clog2(DEPTH);

  logic                 req_fire;
  logic [CntW-1:0]      count_q;
  logic [CntW-1:0]      count_d;
  shift_t               shift;
  logic                 rd_en;
  logic [IdxW-1:0]      rd_idx;
  logic [STAT_W-1:0]    status;
  logic [POS_W-1:0]     where;
  logic [WIDTH-1:0]     word;
  logic [WIDTH+DATA_W-1:0] word_ext;
  logic [WIDTH-1:0]     rd_word;
  logic [WIDTH+DATA_W-1:0] rd_ext;
  logic [WIDTH-1:0]     cell_q [DEPTH];

  logic                 rsp_valid_q;
  logic [DATA_W-1:0]    rsp_data_q;
  logic [STAT_W-1:0]    rsp_status_q;
  logic [POS_W-1:0]     rsp_occ_q;
  logic [POS_W-1:0]     rsp_pos_q;

  // Accept while the response register is free or draining
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;

  // Keep the low WIDTH bits of the incoming value
  assign word_ext = {{WIDTH{1'b0}}, req_i.value};
  assign word     = word_ext[WIDTH-1:0];

  deq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .operation_i (req_i.operation),
    .position_i  (req_i.position),
    .count_i     (count_q),
    .count_o     (count_d),
    .shift_o     (shift),
    .rd_en_o     (rd_en),
    .rd_idx_o    (rd_idx),
    .status_o    (status),
    .where_o     (where)
  );

  // Row of cells, each wired to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] left;
    logic [WIDTH-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_mid_r
      assign right = cell_q[i+1];
    end
    deq_cell #(
      .WIDTH (WIDTH),
      .IDX   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .en_i    (req_fire),
      .shift_i (shift),
      .word_i  (word),
      .left_i  (left),
      .right_i (right),
      .q_o     (cell_q[i])
    );
  end

  // Select the word that leaves or is read; zero otherwise
  assign rd_word = rd_en ? cell_q[rd_idx] : '0;
  assign rd_ext  = {{DATA_W{1'b0}}, rd_word};

  // Hold the element count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (req_fire) begin
      count_q <= count_d;
    end
  end

  // Response valid: set on accept, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rsp_data_q   <= rd_ext[DATA_W-1:0];
      rsp_status_q <= status;
      rsp_occ_q    <= POS_W'(count_d);
      rsp_pos_q    <= where;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.read_data       = rsp_data_q;
  assign rsp_o.status          = rsp_status_q;
  assign rsp_o.occupancy       = rsp_occ_q;
  assign rsp_o.result_position = rsp_pos_q;

endmodule

`default_nettype wire

// ===== hw/rtl/deq_checker.sv =====
// Port-level checks on the queue response channel, bound to the top level.
`default_nettype none

module deq_checker
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              valid_i,
  input wire logic              ready_i,
  input wire logic [DATA_W-1:0] read_data_i,
  input wire logic [STAT_W-1:0] status_i,
  input wire logic [POS_W-1:0]  occupancy_i,
  input wire logic [POS_W-1:0]  result_position_i
);

  localparam logic [POS_W-1:0] FullOcc = POS_W'(DEPTH);

  // A stalled response word holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(read_data_i)
      && $stable(status_i) && $stable(result_position_i))
    else $error("response changed while stalled");

  // A refused operation reports the count as its position
  a_err_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && status_i != ST_OK |-> result_position_i == occupancy_i)
    else $error("error response position differs from occupancy");

  // Full is only reported at capacity
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && status_i == ST_FULL |-> occupancy_i == FullOcc)
    else $error("full status below capacity");

  // Empty is only reported with nothing stored and no data
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && status_i == ST_EMPTY |-> occupancy_i == '0 && read_data_i == '0)
    else $error("empty status with elements or data");

endmodule

bind double_ended_queue_insert_erase_core deq_checker #(
  .DEPTH (DEPTH)
) u_deq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .valid_i           (rsp_o.valid),
  .ready_i           (rsp_o.ready),
  .read_data_i       (rsp_o.read_data),
  .status_i          (rsp_o.status),
  .occupancy_i       (rsp_o.occupancy),
  .result_position_i (rsp_o.result_position)
);

`default_nettype wire

// ===== tb/deq_tb_pkg.sv =====
// Scoreboard with a shadow copy of the queue that predicts every response.
`timescale 1ns / 100ps

package deq_tb_pkg;
  import deq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  occupancy;
    logic [POS_W-1:0]  result_position;
  } deq_result_t;

  class deq_scoreboard;
    logic [DATA_W-1:0] cells [QUEUE_DEPTH];
    int unsigned       count;
    int unsigned       peak;
    int unsigned       errors;
    deq_result_t       pending_results [$];
    int unsigned       op_seen [8];
    int unsigned       status_seen [4];

    function new();
      foreach (cells[i]) cells[i] = '0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      count  = 0;
      peak   = 0;
      errors = 0;
    endfunction

    // Apply one operation to the shadow store and return the response it yields
    function deq_result_t apply_operation(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                          logic [DATA_W-1:0] value);
      deq_result_t       res;
      logic [STAT_W-1:0] st;
      logic [DATA_W-1:0] data;
      int unsigned       where;
      int unsigned       idx;
      st    = ST_OK;
      data  = '0;
      where = count;
      case (op)
        OP_PUSH_BACK: begin
          if (count >= QUEUE_DEPTH) st = ST_FULL;
          else begin
            cells[count] = value;
            where = count;
            count++;
          end
        end
        OP_PUSH_FRONT: begin
          if (count >= QUEUE_DEPTH) st = ST_FULL;
          else begin
            for (idx = count; idx > 0; idx--) cells[idx] = cells[idx-1];
            cells[0] = value;
            count++;
            where = 0;
          end
        end
        OP_POP_BACK: begin
          if (count == 0) st = ST_EMPTY;
          else begin
            count--;
            data  = cells[count];
            where = count;
          end
        end
        OP_POP_FRONT: begin
          if (count == 0) st = ST_EMPTY;
          else begin
            data = cells[0];
            for (idx = 1; idx < count; idx++) cells[idx-1] = cells[idx];
            count--;
            where = 0;
          end
        end
        OP_INSERT: begin
          // a bad index wins over a full queue
          if (pos > count) st = ST_BAD_INDEX;
          else if (count >= QUEUE_DEPTH) st = ST_FULL;
          else begin
            for (idx = count; idx > pos; idx--) cells[idx] = cells[idx-1];
            cells[pos] = value;
            count++;
            where = pos;
          end
        end
        OP_ERASE: begin
          if (pos >= count) st = ST_BAD_INDEX;
          else begin
            data = cells[pos];
            for (idx = pos + 1; idx < count; idx++) cells[idx-1] = cells[idx];
            count--;
            where = pos;
          end
        end
        OP_READ: begin
          if (pos >= count) st = ST_BAD_INDEX;
          else begin
            data  = cells[pos];
            where = pos;
          end
        end
        default: begin
          // clear leaves stale words that are never read again
          count = 0;
          where = 0;
        end
      endcase
      if (st != ST_OK) where = count;
      res.read_data       = data;
      res.status          = st;
      res.occupancy       = count[POS_W-1:0];
      res.result_position = where[POS_W-1:0];
      return res;
    endfunction

    // Note an accepted request word and queue its expected response
    function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] value);
      deq_result_t res;
      res = apply_operation(op, pos, value);
      pending_results.insert(pending_results.size(), res);
      op_seen[op]++;
      status_seen[res.status]++;
      if (count > peak) peak = count;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    task report_mismatch(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    // Compare a response word with the oldest expectation, field by field
    task check_response(logic [DATA_W-1:0] read_data, logic [STAT_W-1:0] status,
                        logic [POS_W-1:0] occupancy, logic [POS_W-1:0] result_position);
      deq_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("response word with nothing expected (data 0x%0h)",
                                  read_data));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (read_data !== want.read_data)
          report_mismatch($sformatf("read_data 0x%0h, expected 0x%0h",
                                    read_data, want.read_data));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, expected %0d",
                                    occupancy, want.occupancy));
        if (result_position !== want.result_position)
          report_mismatch($sformatf("result_position %0d, expected %0d",
                                    result_position, want.result_position));
      end
    endtask

    function void summarize();
      $display("Ran %0d words: push back %0d, push front %0d, pop back %0d, pop front %0d,",
               op_seen.sum(), op_seen[OP_PUSH_BACK], op_seen[OP_PUSH_FRONT],
               op_seen[OP_POP_BACK], op_seen[OP_POP_FRONT]);
      $display("  insert %0d, erase %0d, read %0d, clear %0d",
               op_seen[OP_INSERT], op_seen[OP_ERASE], op_seen[OP_READ],
               op_seen[OP_CLEAR]);
      $display("Outcomes: ok %0d, empty %0d, full %0d, bad index %0d;",
               status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
               status_seen[ST_BAD_INDEX]);
      $display("  deepest fill %0d; errors %0d", peak, errors);
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// Top of the double-ended queue testbench: clock, reset, stimulus and response sink.
`timescale 1ns / 100ps

module tb_top;
  import deq_pkg::*;
  import deq_tb_pkg::*;

  localparam int unsigned ITEM_TOTAL   = 1650;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int          FILL_BIAS    = 0;
  localparam int          DRAIN_BIAS   = 1;
  localparam int          MIXED_BIAS   = 2;

  localparam logic [OP_W-1:0] OP_ORDER [8] = '{OP_PUSH_BACK, OP_PUSH_FRONT, OP_POP_BACK,
                                              OP_POP_FRONT, OP_INSERT, OP_ERASE,
                                              OP_READ, OP_CLEAR};
  // Cumulative percent per operation, in OP_ORDER, for each bias
  localparam int unsigned OP_CUTS [3][8] = '{
    '{30, 55, 60, 65, 85, 89, 98, 100},
    '{ 5, 10, 35, 60, 65, 85, 98, 100},
    '{14, 28, 42, 56, 70, 84, 97, 100}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  deq_req_if req_if ();
  deq_rsp_if rsp_if ();

  deq_scoreboard sb;
  int unsigned   cycles = 0;
  int unsigned   rsp_words = 0;
  bit            send_steady = 1'b0;
  bit            recv_steady = 1'b0;

  double_ended_queue_insert_erase_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // End the run if the traffic never drains
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("double_ended_queue_insert_erase_core: mismatch");
      $finish;
    end
  end

  // Offer one request word, after a random idle gap unless steady, and hold it until accepted
  task automatic send_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic [DATA_W-1:0] value);
    int unsigned gap;
    gap = send_steady ? 0 : $urandom_range(9);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.position  <= pos;
    req_if.value     <= value;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(op, pos, value);
  endtask

  // Drop valid and wait until every expected response has come back
  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] draw_value();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  // Mostly in-range positions for the current fill, sometimes anything the field holds
  function automatic logic [POS_W-1:0] draw_position(logic [OP_W-1:0] op);
    if ($urandom_range(4) == 0) return POS_W'($urandom_range(31));
    if (op == OP_INSERT) return POS_W'($urandom_range(sb.count));
    if (sb.count == 0) return '0;
    return POS_W'($urandom_range(sb.count - 1));
  endfunction

  function automatic logic [OP_W-1:0] pick_operation(int bias);
    int unsigned roll;
    roll = $urandom_range(99);
    for (int k = 0; k < 8; k++) begin
      if (roll < OP_CUTS[bias][k]) return OP_ORDER[k];
    end
    return OP_CLEAR;
  endfunction

  // Corner cases: empty queue, ends of the value range, full queue, bad indexes
  task automatic run_directed();
    send_word(OP_POP_BACK, '0, '0);
    send_word(OP_POP_FRONT, '0, '0);
    send_word(OP_ERASE, '0, '0);
    send_word(OP_READ, '0, '0);
    send_word(OP_INSERT, 5'd1, 32'h1234_5678);
    send_word(OP_INSERT, '0, '0);
    send_word(OP_PUSH_BACK, '1, '1);
    send_word(OP_PUSH_FRONT, '0, 32'hA5A5_5A5A);
    send_word(OP_INSERT, 5'd3, 32'h0F0F_F0F0);
    send_word(OP_READ, '1, '0);
    send_word(OP_ERASE, 5'd1, '0);
    while (sb.count < QUEUE_DEPTH) begin
      if ($urandom_range(1) == 0) send_word(OP_PUSH_BACK, draw_position(OP_PUSH_BACK),
                                            draw_value());
      else send_word(OP_INSERT, POS_W'($urandom_range(sb.count)), draw_value());
    end
    send_word(OP_PUSH_BACK, '0, '1);
    send_word(OP_PUSH_FRONT, '0, '1);
    send_word(OP_INSERT, 5'd17, '1);
    send_word(OP_INSERT, 5'd8, '1);
    send_word(OP_ERASE, 5'd16, '0);
    send_word(OP_READ, 5'd15, '0);
    send_word(OP_POP_BACK, '0, '0);
    send_word(OP_POP_FRONT, '0, '0);
    send_word(OP_CLEAR, '0, '0);
    send_word(OP_POP_BACK, '0, '0);
  endtask

  // Random traffic in phases that fill, drain or mix, so both ends get reached
  task automatic run_random();
    int bias;
    logic [OP_W-1:0] op;
    bias = MIXED_BIAS;
    for (int unsigned n = 0; n < ITEM_TOTAL; n++) begin
      if (n % 64 == 0) bias = $urandom_range(2);
      if (n % 100 == 0) send_steady = ($urandom_range(9) < 3);
      if (n == 600 || n == 1300) hold_until_drained();
      op = pick_operation(bias);
      send_word(op, draw_position(op), draw_value());
    end
  endtask

  // Response sink: random stalls, two long hold-offs to back the block up
  initial begin : response_sink
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rsp_words % 100 == 0) recv_steady = ($urandom_range(9) < 3);
      stall = recv_steady ? 0 : $urandom_range(9);
      if (rsp_words == 400 || rsp_words == 1200) stall = HOLD_CYCLES;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      sb.check_response(rsp_if.read_data, rsp_if.status, rsp_if.occupancy,
                        rsp_if.result_position);
      rsp_words++;
    end
  end

  initial begin : stimulus
    sb = new();
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_PUSH_BACK;
    req_if.position  <= '0;
    req_if.value     <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.summarize();
    if (sb.errors == 0) begin
      $display("double_ended_queue_insert_erase_core: match");
    end else begin
      $display("double_ended_queue_insert_erase_core: mismatch");
    end
    $finish;
  end

endmodule
